/* rtl/frp_pkg.sv */
`timescale 1ns / 1ps
package frp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_DEGREE = 5;
    localparam int DATA_W     = 32;
    localparam int IN_W       = 24;
    localparam int X_W        = IN_W + 1;
    localparam int TOL_W      = 15;
    localparam int ITER_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int INDEX_W    = 3;
    localparam int WIDTH_W    = FRAC_BITS;
    localparam int NUM_W      = DATA_W + WIDTH_W + 1;
    localparam int DEN_W      = DATA_W + 1;
    localparam int QUO_W      = WIDTH_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [X_W-1:0] HALF = X_W'(1) << (FRAC_BITS - 1);

    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LEFT      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RIGHT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CONVERGED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CAP       = 3'd4;

    localparam logic [INDEX_W-1:0] REG_COEF_X5  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_COEF_X4  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_COEF_X3  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_COEF_X2  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_COEF_X1  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_COEF_X0  = 3'd5;
    localparam logic [INDEX_W-1:0] REG_TOLERANCE = 3'd6;
    localparam logic [INDEX_W-1:0] REG_MAX_ITER = 3'd7;

    typedef struct packed {
        logic [MAX_DEGREE:0][DATA_W-1:0] coef;
        logic [TOL_W-1:0]                tol;
        logic [ITER_W-1:0]               max_iter;
    } cfg_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return DATA_W'(hi);
        end else if (v < lo) begin
            return DATA_W'(lo);
        end
        return DATA_W'(v);
    endfunction

    // |f| < tol
    function automatic logic mag_lt(input logic signed [DATA_W-1:0] f,
                                    input logic [TOL_W-1:0] tol);
        logic signed [DATA_W:0] fe;
        logic [DATA_W:0] m;
        fe = (DATA_W+1)'(f);
        m  = fe[DATA_W] ? (DATA_W+1)'(-fe) : fe;
        return m < (DATA_W+1)'(tol);
    endfunction

    function automatic logic opposite(input logic signed [DATA_W-1:0] a,
                                      input logic signed [DATA_W-1:0] b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

endpackage

/* rtl/frp_queue.sv */
`timescale 1ns / 1ps
module frp_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_valid,
    output logic                       wr_ready,
    input  logic [frp_pkg::IN_W-1:0]   wr_data,
    output logic                       rd_valid,
    input  logic                       rd_pop,
    output logic [frp_pkg::IN_W-1:0]   rd_data
);
    logic [frp_pkg::IN_W-1:0] mem [frp_pkg::QUEUE_DEPTH];
    logic [frp_pkg::QPTR_W-1:0] wptr_reg;
    logic [frp_pkg::QPTR_W-1:0] rptr_reg;
    logic [frp_pkg::QPTR_W:0]   count_reg;
    logic push;
    logic pop;

    assign wr_ready = count_reg < (frp_pkg::QPTR_W+1)'(frp_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (frp_pkg::QPTR_W+1)'(push) - (frp_pkg::QPTR_W+1)'(pop);
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (frp_pkg::QPTR_W+1)'(frp_pkg::QUEUE_DEPTH))
        else $error("queue over capacity");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |=> (count_reg <= 1))
        else $error("queue underflow");
    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push lost");
endmodule

/* rtl/frp_div.sv */
`timescale 1ns / 1ps
module frp_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [frp_pkg::NUM_W-1:0]    num,
    input  logic signed [frp_pkg::DEN_W-1:0]    den,
    output logic                                busy,
    output logic                                done,
    output logic signed [frp_pkg::QUO_W-1:0]    quo
);
    localparam int STEPS = frp_pkg::WIDTH_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [frp_pkg::DEN_W-1:0]   dmag_reg;
    logic [frp_pkg::DEN_W-1:0]   rem_reg;
    logic [STEPS-1:0]            low_reg;
    logic [STEPS-1:0]            q_reg;
    logic                        neg_reg;
    logic                        zero_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [frp_pkg::NUM_W-1:0]   nmag;
    logic [frp_pkg::DEN_W-1:0]   dmag;
    logic [frp_pkg::DEN_W:0]     trial;
    logic                        fits;

    assign nmag  = num[frp_pkg::NUM_W-1] ? frp_pkg::NUM_W'(-num) : num;
    assign dmag  = den[frp_pkg::DEN_W-1] ? frp_pkg::DEN_W'(-den) : den;
    assign trial = {rem_reg, low_reg[STEPS-1]};
    assign fits  = trial >= (frp_pkg::DEN_W+1)'(dmag_reg);

    always_ff @(posedge aclk) begin
        if (start) begin
            dmag_reg <= dmag;
            rem_reg  <= frp_pkg::DEN_W'(nmag[frp_pkg::NUM_W-1:STEPS]);
            low_reg  <= nmag[STEPS-1:0];
            neg_reg  <= num[frp_pkg::NUM_W-1] ^ den[frp_pkg::DEN_W-1];
            zero_reg <= den == '0;
            q_reg    <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? frp_pkg::DEN_W'(trial - (frp_pkg::DEN_W+1)'(dmag_reg))
                            : frp_pkg::DEN_W'(trial);
            low_reg <= {low_reg[STEPS-2:0], 1'b0};
            q_reg   <= {q_reg[STEPS-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    // truncation toward zero: divide magnitudes, then restore the sign
    assign quo  = zero_reg ? '0
                : neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule

/* rtl/frp_engine.sv */
`timescale 1ns / 1ps
module frp_engine (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  frp_pkg::cfg_t                         cfg,
    input  logic                                  q_valid,
    input  logic [frp_pkg::IN_W-1:0]              q_data,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [frp_pkg::STATUS_W-1:0]          m_status,
    output logic signed [frp_pkg::DATA_W-1:0]     m_root,
    output logic [frp_pkg::ITER_W-1:0]            m_iterations
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_ADD  = 4'd2;
    localparam logic [3:0] S_GOT1 = 4'd3;
    localparam logic [3:0] S_GOT2 = 4'd4;
    localparam logic [3:0] S_LOOP = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_GOT0 = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam int PROD_W = frp_pkg::DATA_W + frp_pkg::X_W;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;
    logic signed [frp_pkg::X_W-1:0] x1_reg, x1_next;
    logic signed [frp_pkg::X_W-1:0] x2_reg, x2_next;
    logic signed [frp_pkg::X_W-1:0] x0_reg, x0_next;
    logic signed [frp_pkg::X_W-1:0] evx_reg, evx_next;
    logic signed [frp_pkg::DATA_W-1:0] f1_reg, f1_next;
    logic signed [frp_pkg::DATA_W-1:0] f2_reg, f2_next;
    logic signed [frp_pkg::DATA_W-1:0] r_reg, r_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [2:0] deg_reg, deg_next;
    logic [frp_pkg::ITER_W-1:0] iters_reg, iters_next;
    logic [frp_pkg::STATUS_W-1:0] status_reg, status_next;
    logic m_valid_reg;
    logic [frp_pkg::STATUS_W-1:0] m_status_reg;
    logic signed [frp_pkg::DATA_W-1:0] m_root_reg;
    logic [frp_pkg::ITER_W-1:0] m_iter_reg;

    logic signed [frp_pkg::DATA_W-1:0] horner_sum;
    logic signed [frp_pkg::X_W:0] width;
    logic signed [frp_pkg::NUM_W-1:0] num;
    logic signed [frp_pkg::DEN_W-1:0] den;
    logic div_start, div_busy, div_done;
    logic signed [frp_pkg::QUO_W-1:0] quo;
    logic load_out;

    always_comb begin
        logic signed [frp_pkg::DATA_W-1:0] p;
        p = frp_pkg::sat32(64'(prod_reg >>> frp_pkg::FRAC_BITS));
        horner_sum = frp_pkg::sat32(64'(p)
                   + 64'($signed(cfg.coef[deg_reg - 3'd1])));
    end

    assign width = (frp_pkg::X_W+1)'(x2_reg) - (frp_pkg::X_W+1)'(x1_reg);
    assign num   = f1_reg * $signed({1'b0, width[frp_pkg::WIDTH_W-1:0]});
    assign den   = (frp_pkg::DEN_W)'(f2_reg) - (frp_pkg::DEN_W)'(f1_reg);

    frp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (quo)
    );

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        x1_next     = x1_reg;
        x2_next     = x2_reg;
        x0_next     = x0_reg;
        evx_next    = evx_reg;
        f1_next     = f1_reg;
        f2_next     = f2_reg;
        r_next      = r_reg;
        deg_next    = deg_reg;
        iters_next  = iters_reg;
        status_next = status_reg;
        q_pop       = 1'b0;
        div_start   = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    x1_next    = frp_pkg::X_W'($signed(q_data));
                    x2_next    = frp_pkg::X_W'($signed(q_data)) + $signed(frp_pkg::HALF);
                    evx_next   = frp_pkg::X_W'($signed(q_data));
                    iters_next = '0;
                    r_next     = $signed(cfg.coef[frp_pkg::MAX_DEGREE]);
                    deg_next   = 3'(frp_pkg::MAX_DEGREE);
                    ret_next   = S_GOT1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_ADD;
            end
            S_ADD: begin
                r_next   = horner_sum;
                deg_next = deg_reg - 3'd1;
                state_next = (deg_reg == 3'd1) ? ret_reg : S_MUL;
            end
            S_GOT1: begin
                f1_next    = r_reg;
                evx_next   = x2_reg;
                r_next     = $signed(cfg.coef[frp_pkg::MAX_DEGREE]);
                deg_next   = 3'(frp_pkg::MAX_DEGREE);
                ret_next   = S_GOT2;
                state_next = S_MUL;
            end
            S_GOT2: begin
                f2_next    = r_reg;
                state_next = S_OUT;
                if (frp_pkg::mag_lt(f1_reg, cfg.tol)) begin
                    status_next = frp_pkg::ST_LEFT;
                    x0_next     = x1_reg;
                end else if (frp_pkg::mag_lt(r_reg, cfg.tol)) begin
                    status_next = frp_pkg::ST_RIGHT;
                    x0_next     = x2_reg;
                end else if (frp_pkg::opposite(f1_reg, r_reg)) begin
                    status_next = frp_pkg::ST_CONVERGED;
                    x0_next     = x1_reg;
                    state_next  = S_LOOP;
                end else begin
                    status_next = frp_pkg::ST_NONE;
                    x0_next     = '0;
                end
            end
            S_LOOP: begin
                if (width <= (frp_pkg::X_W+1)'(cfg.tol)) begin
                    state_next = S_OUT;
                end else if (iters_reg >= cfg.max_iter) begin
                    status_next = frp_pkg::ST_CAP;
                    state_next  = S_OUT;
                end else begin
                    iters_next = iters_reg + 1'b1;
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    x0_next    = x1_reg - frp_pkg::X_W'(quo);
                    evx_next   = x1_reg - frp_pkg::X_W'(quo);
                    r_next     = $signed(cfg.coef[frp_pkg::MAX_DEGREE]);
                    deg_next   = 3'(frp_pkg::MAX_DEGREE);
                    ret_next   = S_GOT0;
                    state_next = S_MUL;
                end
            end
            S_GOT0: begin
                if (frp_pkg::mag_lt(r_reg, cfg.tol)) begin
                    state_next = S_OUT;
                end else begin
                    if (frp_pkg::opposite(r_reg, f1_reg)) begin
                        x2_next = x0_reg;
                        f2_next = r_reg;
                    end else begin
                        x1_next = x0_reg;
                        f1_next = r_reg;
                    end
                    state_next = S_LOOP;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ret_reg    <= ret_next;
        x1_reg     <= x1_next;
        x2_reg     <= x2_next;
        x0_reg     <= x0_next;
        evx_reg    <= evx_next;
        f1_reg     <= f1_next;
        f2_reg     <= f2_next;
        r_reg      <= r_next;
        deg_reg    <= deg_next;
        status_reg <= status_next;
        prod_reg   <= r_reg * evx_reg;
        if (load_out) begin
            m_status_reg <= status_reg;
            m_root_reg   <= frp_pkg::DATA_W'(x0_reg);
            m_iter_reg   <= iters_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            iters_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            iters_reg <= iters_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_root       = m_root_reg;
    assign m_iterations = m_iter_reg;

    a_div_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider running outside its wait state");
    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (state_reg == S_OUT) && (!m_valid_reg || m_ready))
        else $error("result overwritten before transaction");
    a_none_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) && (m_status_reg == frp_pkg::ST_NONE)
        |-> (m_root_reg == '0) && (m_iter_reg == '0))
        else $error("no-root result carries data");
endmodule

/* rtl/false_position_root_finder.sv */
`timescale 1ns / 1ps
// false position root search of a degree-five polynomial over [x, x + 0.5]
// input channel s_*: one transaction carries the signed Q8.16 left end of the interval
// output channel m_*: one transaction per input with status, root and iteration count
// configuration: cfg_we writes cfg_data to register cfg_index (coefficients x5..x0,
// tolerance, iteration cap); write only while no transaction is in flight
// a two-entry queue takes inputs while the search engine is busy
// sequence: the engine pops an accepted input and runs two horner evaluations
// through S_MUL and S_ADD, left end then right end, classifies the ends in S_GOT2
// and loads the result in S_OUT; each iteration starts the divider in S_LOOP, waits
// in S_DIV, evaluates at x0 and updates the bracket, and a closing width or cap check runs
// throughput: one interval at a time, set by the single shared multiplier and
// the bit-serial divider; the next interval is taken from the queue once a result is loaded
// reset: coefficients return to p(x) = x, tolerance 7, cap 100; queue emptied
// a stalled m_ready holds the result; the engine waits with the next result
// finished until the output register frees, and the queue fills then back-pressures
module false_position_root_finder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [frp_pkg::IN_W-1:0]     s_interval_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [frp_pkg::STATUS_W-1:0]        m_status,
    output logic signed [frp_pkg::DATA_W-1:0]   m_root,
    output logic [frp_pkg::ITER_W-1:0]          m_iterations,
    input  logic                                cfg_we,
    input  logic [frp_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [frp_pkg::DATA_W-1:0]          cfg_data
);
    frp_pkg::cfg_t cfg_reg;
    logic q_valid;
    logic q_pop;
    logic [frp_pkg::IN_W-1:0] q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef[5]  <= '0;
            cfg_reg.coef[4]  <= '0;
            cfg_reg.coef[3]  <= '0;
            cfg_reg.coef[2]  <= '0;
            cfg_reg.coef[1]  <= frp_pkg::DATA_W'(1) << frp_pkg::FRAC_BITS;
            cfg_reg.coef[0]  <= '0;
            cfg_reg.tol      <= frp_pkg::TOL_W'(7);
            cfg_reg.max_iter <= frp_pkg::ITER_W'(100);
        end else if (cfg_we) begin
            case (cfg_index)
                frp_pkg::REG_COEF_X5:   cfg_reg.coef[5] <= cfg_data;
                frp_pkg::REG_COEF_X4:   cfg_reg.coef[4] <= cfg_data;
                frp_pkg::REG_COEF_X3:   cfg_reg.coef[3] <= cfg_data;
                frp_pkg::REG_COEF_X2:   cfg_reg.coef[2] <= cfg_data;
                frp_pkg::REG_COEF_X1:   cfg_reg.coef[1] <= cfg_data;
                frp_pkg::REG_COEF_X0:   cfg_reg.coef[0] <= cfg_data;
                frp_pkg::REG_TOLERANCE: cfg_reg.tol <= cfg_data[frp_pkg::TOL_W-1:0];
                frp_pkg::REG_MAX_ITER:  cfg_reg.max_iter <= cfg_data[frp_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    frp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (s_interval_start),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    frp_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_root       (m_root),
        .m_iterations (m_iterations)
    );
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;

    localparam longint CYCLE_LIMIT = 64'd100_000_000;
    localparam int      LONG_HOLD   = 3000;

    typedef struct {
        logic [frp_pkg::STATUS_W-1:0]      status;
        logic signed [frp_pkg::DATA_W-1:0] root;
        logic [frp_pkg::ITER_W-1:0]        iterations;
    } root_result_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [frp_pkg::IN_W-1:0]    s_interval_start;
    logic                               m_valid;
    logic                               m_ready;
    logic [frp_pkg::STATUS_W-1:0]       m_status;
    logic signed [frp_pkg::DATA_W-1:0]  m_root;
    logic [frp_pkg::ITER_W-1:0]         m_iterations;
    logic                               cfg_we;
    logic [frp_pkg::INDEX_W-1:0]        cfg_index;
    logic [frp_pkg::DATA_W-1:0]         cfg_data;

    false_position_root_finder dut (.*);

    // local copy of the configuration, coefficients indexed by power
    longint poly_coef [0:frp_pkg::MAX_DEGREE];
    longint tol_q;
    longint iter_cap;

    logic signed [frp_pkg::IN_W-1:0] pending_starts [$];
    root_result_t                    expected_roots [$];

    int     idle_mode;      // 0 none, 1 sender, 2 receiver, 3 both light
    int     errors;
    int     status_seen [0:7];
    longint cycles;
    logic   in_fire;
    logic   hold_go;
    logic   hold_done;
    int     hold_left;
    real    roots [0:frp_pkg::MAX_DEGREE-1];
    int     n_roots;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint eval_poly(input longint x);
        longint acc;
        longint prod;
        acc = poly_coef[frp_pkg::MAX_DEGREE];
        for (int d = frp_pkg::MAX_DEGREE - 1; d >= 0; d--) begin
            prod = clamp32((acc * x) >>> frp_pkg::FRAC_BITS);
            acc  = clamp32(prod + poly_coef[d]);
        end
        return acc;
    endfunction

    function automatic longint absval(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit signs_differ(input longint a, input longint b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    function automatic root_result_t search_interval(
        input logic signed [frp_pkg::IN_W-1:0] start);
        root_result_t res;
        longint x1, x2, x0, f1, f2, f0, den, q;
        int     n;
        x1 = longint'(start);
        x2 = x1 + (64'sd1 <<< (frp_pkg::FRAC_BITS - 1));
        f1 = eval_poly(x1);
        f2 = eval_poly(x2);
        x0 = 0;
        n  = 0;
        res.status = frp_pkg::ST_NONE;
        if (absval(f1) < tol_q) begin
            res.status = frp_pkg::ST_LEFT;
            x0 = x1;
        end else if (absval(f2) < tol_q) begin
            res.status = frp_pkg::ST_RIGHT;
            x0 = x2;
        end else if (signs_differ(f1, f2)) begin
            x0 = x1;
            res.status = frp_pkg::ST_CONVERGED;
            while (x2 - x1 > tol_q) begin
                if (n >= iter_cap) begin
                    res.status = frp_pkg::ST_CAP;
                    break;
                end
                n++;
                den = f2 - f1;
                q   = (den != 0) ? (f1 * (x2 - x1)) / den : 0;
                x0  = x1 - q;
                f0  = eval_poly(x0);
                if (absval(f0) < tol_q) break;
                if (signs_differ(f0, f1)) begin
                    x2 = x0;
                    f2 = f0;
                end else begin
                    x1 = x0;
                    f1 = f0;
                end
            end
        end
        res.root       = frp_pkg::DATA_W'(x0);
        res.iterations = frp_pkg::ITER_W'(n);
        return res;
    endfunction

    function automatic bit pick(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic report(input string field, input longint got, input longint want);
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 field, cycles, got, want);
        errors++;
    endtask

    task automatic add_start(input logic signed [frp_pkg::IN_W-1:0] v);
        pending_starts = {pending_starts, v};
    endtask

    // predictor and result checker
    always @(posedge aclk) begin
        root_result_t w;
        in_fire <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            expected_roots = {expected_roots, search_interval(s_interval_start)};
        if (aresetn && m_valid && m_ready) begin
            if (expected_roots.size() == 0) begin
                report("unexpected transaction", 1, 0);
            end else begin
                w = expected_roots.pop_front();
                status_seen[w.status]++;
                if (m_status !== w.status) report("status", m_status, w.status);
                if (m_root !== w.root) report("root", m_root, w.root);
                if (m_iterations !== w.iterations)
                    report("iterations", m_iterations, w.iterations);
            end
        end
    end

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_starts.size() > 0 &&
                !((idle_mode == 1 && pick(86)) || (idle_mode == 3 && pick(14)))) begin
                s_valid          <= 1'b1;
                s_interval_start <= pending_starts.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !((idle_mode == 2 && pick(86)) || (idle_mode == 3 && pick(14)));
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [frp_pkg::INDEX_W-1:0] idx,
                             input logic [frp_pkg::DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == frp_pkg::REG_TOLERANCE)
            tol_q = longint'(val[frp_pkg::TOL_W-1:0]);
        else if (idx == frp_pkg::REG_MAX_ITER)
            iter_cap = longint'(val[frp_pkg::ITER_W-1:0]);
        else
            poly_coef[frp_pkg::MAX_DEGREE - idx] = longint'(signed'(val));
    endtask

    task automatic set_coefs(input logic [frp_pkg::DATA_W-1:0] c5, c4, c3, c2, c1, c0);
        write_reg(frp_pkg::REG_COEF_X5, c5);
        write_reg(frp_pkg::REG_COEF_X4, c4);
        write_reg(frp_pkg::REG_COEF_X3, c3);
        write_reg(frp_pkg::REG_COEF_X2, c2);
        write_reg(frp_pkg::REG_COEF_X1, c1);
        write_reg(frp_pkg::REG_COEF_X0, c0);
    endtask

    // wait for every transaction to come back, then let the engine settle
    task automatic drain;
        while (pending_starts.size() != 0 || s_valid || expected_roots.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [frp_pkg::DATA_W-1:0] to_fixed(input real v);
        real s;
        s = v * 65536.0;
        if (s > 2147483647.0) s = 2147483647.0;
        if (s < -2147483648.0) s = -2147483648.0;
        return frp_pkg::DATA_W'($rtoi(s));
    endfunction

    // random polynomial built from random real roots, so brackets are easy to aim at
    task automatic random_poly;
        real c [0:frp_pkg::MAX_DEGREE];
        real lead;
        n_roots = $urandom_range(frp_pkg::MAX_DEGREE, 1);
        lead = ($urandom_range(400, 10) / 100.0) * ($urandom_range(1) ? 1.0 : -1.0);
        for (int i = 0; i <= frp_pkg::MAX_DEGREE; i++) c[i] = 0.0;
        c[0] = lead;
        for (int k = 0; k < n_roots; k++) begin
            roots[k] = ($itor($urandom_range(800000)) - 400000.0) / 65536.0;
            for (int i = k + 1; i >= 1; i--) c[i] = c[i - 1] - roots[k] * c[i];
            c[0] = -roots[k] * c[0];
        end
        set_coefs(to_fixed(c[5]), to_fixed(c[4]), to_fixed(c[3]),
                  to_fixed(c[2]), to_fixed(c[1]), to_fixed(c[0]));
    endtask

    function automatic logic signed [frp_pkg::IN_W-1:0] near_root();
        real r;
        r = roots[$urandom_range(n_roots - 1)] * 65536.0;
        return frp_pkg::IN_W'($rtoi(r) - $urandom_range(32768));
    endfunction

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++) begin
            if (pick(75)) add_start(near_root());
            else if (pick(50)) add_start(frp_pkg::IN_W'($urandom));
            else add_start(frp_pkg::IN_W'($urandom_range(13107200) - 6553600));
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_interval_start = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_mode = 0;
        errors    = 0;
        cycles    = 0;
        in_fire   = 1'b0;
        hold_go   = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        for (int i = 0; i < 8; i++) status_seen[i] = 0;
        for (int i = 0; i <= frp_pkg::MAX_DEGREE; i++) poly_coef[i] = 0;
        poly_coef[1] = 65536;
        tol_q    = 7;
        iter_cap = 100;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset polynomial p(x) = x: end roots, a bracket, no root, range extremes
        add_start(24'sd0);
        add_start(-24'sd32768);
        add_start(-24'sd16384);
        add_start(-24'sd3);
        add_start(-24'sd6553600);
        add_start(24'sd6553600);
        add_start(-24'sd8388608);
        add_start(24'sd8388607);
        drain();

        // saturating coefficients, a tolerance of 16384 and the highest cap
        set_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 32'h80000000);
        write_reg(frp_pkg::REG_TOLERANCE, 32'd16384);
        write_reg(frp_pkg::REG_MAX_ITER, 32'd255);
        add_start(-24'sd8388608);
        add_start(24'sd8388607);
        add_start(-24'sd16384);
        add_start(24'sd0);
        drain();
        set_coefs(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h7fffffff);
        add_start(-24'sd8388608);
        add_start(24'sd8388607);
        add_start(-24'sd32768);
        drain();

        // zero tolerance: an endpoint exactly at zero is not a sign change
        set_coefs(32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0);
        write_reg(frp_pkg::REG_TOLERANCE, 32'd0);
        add_start(24'sd0);
        add_start(-24'sd32768);
        add_start(-24'sd10000);
        drain();

        // cap of zero stops before the first iteration, cap of one after it
        random_poly();
        write_reg(frp_pkg::REG_MAX_ITER, 32'd0);
        write_reg(frp_pkg::REG_TOLERANCE, 32'd1);
        for (int i = 0; i < 3; i++) add_start(near_root());
        drain();
        write_reg(frp_pkg::REG_MAX_ITER, 32'd1);
        for (int i = 0; i < 3; i++) add_start(near_root());
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            idle_mode = ph % 4;
            random_poly();
            if (ph == 1) write_reg(frp_pkg::REG_TOLERANCE, 32'd1);
            else if (ph == 6) write_reg(frp_pkg::REG_TOLERANCE, 32'd16384);
            else write_reg(frp_pkg::REG_TOLERANCE, $urandom_range(16384, 1));
            if (ph == 5) write_reg(frp_pkg::REG_MAX_ITER, 32'd255);
            else write_reg(frp_pkg::REG_MAX_ITER, $urandom_range(100, 2));
            // the long hold-off lets the input queue fill while items keep coming
            if (ph == 4) hold_go = 1'b1;
            random_items(170);
            drain();
        end
        idle_mode = 0;
        repeat (100) @(posedge aclk);

        $display("results checked: %0d none, %0d left end, %0d right end,",
                 status_seen[frp_pkg::ST_NONE], status_seen[frp_pkg::ST_LEFT],
                 status_seen[frp_pkg::ST_RIGHT]);
        $display("  %0d converged, %0d capped; mismatches: %0d",
                 status_seen[frp_pkg::ST_CONVERGED], status_seen[frp_pkg::ST_CAP], errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
